// ===== rtl/core/mcc_pkg.sv =====
// Shared types, constants and helpers for the minimum coin change block.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package mcc_pkg;

	localparam int AMT_W     = 10;
	localparam int DENOM_W   = 10;
	localparam int CNT_W     = 10;
	localparam int ENTRY_W   = CNT_W + 1;
	localparam int MAX_DENOMS = 6;
	localparam int K_W       = 3;
	localparam int REG_IDX_W = 3;
	localparam int TBL_DEPTH = 2 ** AMT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DENOM_COUNT = 3'd0,
		REG_DENOM_0     = 3'd1,
		REG_DENOM_1     = 3'd2,
		REG_DENOM_2     = 3'd3,
		REG_DENOM_3     = 3'd4,
		REG_DENOM_4     = 3'd5,
		REG_DENOM_5     = 3'd6
	} cfg_reg_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;     // capture target, seed table entry zero, clear result
		logic issue;     // run one denomination slot of the current amount
		logic load_out;  // copy the finished result into the output register
	} mcc_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic tgt_zero;  // captured target is zero
		logic k_last;    // current slot is the last one of this amount
		logic amt_last;  // current amount equals the target
	} mcc_sts_t;

	// Clamp an 11-bit candidate count to the 10-bit field.
	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W:0] v);
		sat_count = v[CNT_W] ? CNT_MAX : v[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/mcc_stream_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
// Depends on mcc_pkg for field widths.
`timescale 1ns / 1ps

interface mcc_req_if;
	logic                         valid;
	logic                         ready;
	logic [mcc_pkg::AMT_W-1:0]    target_amount;

	modport source (output valid, output target_amount, input ready);
	modport sink   (input valid, input target_amount, output ready);
endinterface

interface mcc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mcc_pkg::CNT_W-1:0]    coin_count;
	logic                         unreachable;

	modport source (output valid, output coin_count, output unreachable, input ready);
	modport sink   (input valid, input coin_count, input unreachable, output ready);
endinterface

// ===== rtl/core/mcc_ctrl.sv =====
// Sequencing state machine for the minimum coin change block.
// Depends on mcc_pkg; drives the datapath through mcc_cmd_t.
`timescale 1ns / 1ps

module mcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mcc_pkg::mcc_sts_t sts,
	output mcc_pkg::mcc_cmd_t cmd
);
	import mcc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.start    = (state_q == ST_IDLE) && in_valid;
		cmd.issue    = (state_q == ST_RUN);
		cmd.load_out = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= sts.tgt_zero ? ST_FIN : ST_RUN;
				end
				ST_RUN: begin
					if (sts.k_last && sts.amt_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.load_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mcc_dp.sv =====
// Datapath: denomination registers, best-count table, slot pipeline, result.
// Depends on mcc_pkg; commanded by mcc_ctrl through mcc_cmd_t.
`timescale 1ns / 1ps

module mcc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mcc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [mcc_pkg::DENOM_W-1:0]   wr_data,
	input  logic [mcc_pkg::AMT_W-1:0]     target_amount,
	input  mcc_pkg::mcc_cmd_t             cmd,
	output mcc_pkg::mcc_sts_t             sts,
	output logic [mcc_pkg::CNT_W-1:0]     coin_count,
	output logic                          unreachable
);
	import mcc_pkg::*;

	// configuration
	logic [K_W-1:0]     denom_count_q;
	logic [DENOM_W-1:0] denom_q [MAX_DENOMS];

	// table
	logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];

	// iteration
	logic [AMT_W-1:0]   target_q;
	logic [AMT_W-1:0]   amt_q;
	logic [K_W-1:0]     k_q;

	// slot pipeline
	logic               vld_s1, ok_s1, last_s1, hit_s1;
	logic [AMT_W-1:0]   amt_s1;
	logic [ENTRY_W-1:0] rdata_s1, byp_s1;

	logic               acc_found_q;
	logic [CNT_W:0]     acc_best_q;

	logic [CNT_W-1:0]   res_count_q, out_count_q;
	logic               res_unr_q, out_unr_q;

	logic [K_W-1:0]     used, last_k;
	logic [DENOM_W-1:0] d;
	logic               ok;
	logic [AMT_W-1:0]   rd_addr;
	logic               tbl_we;
	logic [AMT_W-1:0]   tbl_waddr;
	logic [ENTRY_W-1:0] tbl_wdata;
	logic [ENTRY_W-1:0] prev;
	logic               cand_ok, take, new_found;
	logic [CNT_W:0]     cand, new_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denom_count_q <= K_W'(1);
			for (int i = 0; i < MAX_DENOMS; i++)
				denom_q[i] <= DENOM_W'(1);
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_DENOM_COUNT: denom_count_q <= wr_data[K_W-1:0];
				REG_DENOM_0:     denom_q[0] <= wr_data;
				REG_DENOM_1:     denom_q[1] <= wr_data;
				REG_DENOM_2:     denom_q[2] <= wr_data;
				REG_DENOM_3:     denom_q[3] <= wr_data;
				REG_DENOM_4:     denom_q[4] <= wr_data;
				REG_DENOM_5:     denom_q[5] <= wr_data;
				default:         ;
			endcase
		end
	end

	assign used   = (denom_count_q > K_W'(MAX_DENOMS)) ? K_W'(MAX_DENOMS) : denom_count_q;
	assign last_k = (used == '0) ? '0 : used - K_W'(1);

	assign sts.tgt_zero = (target_q == '0);
	assign sts.k_last   = (k_q == last_k);
	assign sts.amt_last = (amt_q == target_q);

	// slot issue: pick denomination, form the table read address
	always_comb begin
		d = '0;
		if (k_q < K_W'(MAX_DENOMS))
			d = denom_q[k_q];
	end
	assign ok      = (k_q < used) && (d != '0) && (d <= amt_q);
	assign rd_addr = amt_q - d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			amt_q    <= '0;
			k_q      <= '0;
		end else if (cmd.start) begin
			target_q <= target_amount;
			amt_q    <= AMT_W'(1);
			k_q      <= '0;
		end else if (cmd.issue) begin
			if (sts.k_last) begin
				k_q   <= '0;
				amt_q <= amt_q + AMT_W'(1);
			end else begin
				k_q <= k_q + K_W'(1);
			end
		end
	end

	// table write: seed entry zero, or retire an amount
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = amt_s1;
		tbl_wdata = {1'b1, sat_count(acc_best_q)};
		if (cmd.start) begin
			tbl_we    = 1'b1;
			tbl_waddr = '0;
			tbl_wdata = {1'b1, {CNT_W{1'b0}}};
		end else if (vld_s1 && last_s1) begin
			tbl_we    = 1'b1;
			tbl_wdata = new_found ? {1'b1, sat_count(new_best)} : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		rdata_s1 <= tbl_mem[rd_addr];
		byp_s1   <= tbl_wdata;
		amt_s1   <= amt_q;
		ok_s1    <= ok;
		last_s1  <= sts.k_last;
		hit_s1   <= tbl_we && (tbl_waddr == rd_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= cmd.issue;
	end

	// compare stage
	assign prev      = hit_s1 ? byp_s1 : rdata_s1;
	assign cand_ok   = ok_s1 && prev[CNT_W];
	assign cand      = {1'b0, prev[CNT_W-1:0]} + (CNT_W+1)'(1);
	assign take      = cand_ok && (!acc_found_q || (cand < acc_best_q));
	assign new_found = acc_found_q || cand_ok;
	assign new_best  = take ? cand : acc_best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_found_q <= 1'b0;
		end else if (cmd.start || (vld_s1 && last_s1)) begin
			acc_found_q <= 1'b0;
		end else if (vld_s1) begin
			acc_found_q <= new_found;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && !last_s1)
			acc_best_q <= new_best;
		else if (cmd.start || vld_s1)
			acc_best_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_count_q <= '0;
			res_unr_q   <= 1'b0;
		end else if (vld_s1 && last_s1 && (amt_s1 == target_q)) begin
			res_count_q <= new_found ? sat_count(new_best) : '0;
			res_unr_q   <= !new_found;
		end
		if (cmd.load_out) begin
			out_count_q <= res_count_q;
			out_unr_q   <= res_unr_q;
		end
	end

	assign coin_count  = out_count_q;
	assign unreachable = out_unr_q;

endmodule

// ===== rtl/core/min_coin_change_dp.sv =====
// Top level of the minimum coin change block: controller plus datapath.
// Depends on mcc_pkg, mcc_stream_if, mcc_ctrl and mcc_dp.
`timescale 1ns / 1ps
//
//  Channel  Dir  Payload                       Transfer when
//  req      in   target_amount[9:0]            req.valid && req.ready
//  rsp      out  coin_count[9:0], unreachable  rsp.valid && rsp.ready
//  wr_*     in   wr_index[2:0], wr_data[9:0]   wr_en
//
//  Each amount from 1 to target runs max(used, 1) denomination slots, where
//  used is the denomination count saturated at 6. One table read per cycle;
//  a zero target skips the slots. Reset clears control and sets the
//  denomination count and every denomination to 1; the table needs no clearing pass.
//  req is taken only when idle; a finished result waits in the rsp register
//  and the next request may be accepted while it stalls.

module min_coin_change_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	mcc_req_if.sink                       req,
	mcc_rsp_if.source                     rsp,
	input  logic                          wr_en,
	input  logic [mcc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [mcc_pkg::DENOM_W-1:0]   wr_data
);
	import mcc_pkg::*;

	mcc_cmd_t cmd;
	mcc_sts_t sts;

	// Sequencer: accepts a request, runs every amount slot by slot (none for a zero target), drains
	// the compare stage, then hands the result to the output register.
	mcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: holds the coin values, the best-count table and the
	// read/compare pipeline with a bypass for the entry just written.
	mcc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.target_amount (req.target_amount),
		.cmd           (cmd),
		.sts           (sts),
		.coin_count    (rsp.coin_count),
		.unreachable   (rsp.unreachable)
	);

endmodule
